>>> rtl/core/rbsa_pkg.sv
// Shared types and constants for the ring buffer space allocator.
`default_nettype none

package rbsa_pkg;

  // Default largest buffer, in bytes.
  localparam int unsigned MAX_BUFFER_BYTES_DEFAULT = 65536;

  // Field widths.
  localparam int unsigned SIZE_W   = 17;
  localparam int unsigned ALIGN_W  = 9;
  localparam int unsigned MASK_W   = 8;
  localparam int unsigned START_W  = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // Buffer size after reset.
  localparam int unsigned RESET_BUFFER_BYTES = 4096;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_ALIGNMENT   = 1'b1;

  // Request functions.
  typedef enum logic [1:0] {
    FN_ALLOC  = 2'd0,
    FN_BEGIN  = 2'd1,
    FN_FINISH = 2'd2,
    FN_QUERY  = 2'd3
  } func_t;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BLOCKED   = 2'd1,
    ST_NO_DATA   = 2'd2,
    ST_TOO_LARGE = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic step;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> rtl/core/rbsa_ctrl.sv
// Controller for the ring buffer space allocator: handshake and result register state.
`default_nettype none

module rbsa_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output rbsa_pkg::ctrl_cmd_t     cmd
);
  import rbsa_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RESULT
  } state_t;

  state_t state;
  logic   accept;

  // A new item may enter whenever the result register is free or being emptied.
  assign in_stall  = (state == S_RESULT) && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = (state == S_RESULT);
  assign cmd.step  = accept;

  // The result register is full after an accepted item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) state <= S_RESULT;
        end
        S_RESULT: begin
          if (!out_stall && !accept) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/rbsa_dp.sv
// Datapath for the ring buffer space allocator: offsets, configuration and result register.
`default_nettype none

module rbsa_dp #(
  parameter int unsigned MAX_BUFFER_BYTES = rbsa_pkg::MAX_BUFFER_BYTES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire rbsa_pkg::ctrl_cmd_t                 cmd,
  input  wire logic                                cfg_write,
  input  wire logic [rbsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rbsa_pkg::SIZE_W-1:0]         cfg_data,
  input  wire logic [1:0]                          func,
  input  wire logic [rbsa_pkg::SIZE_W-1:0]         req_size,
  output logic [1:0]                               status,
  output logic [rbsa_pkg::START_W-1:0]             start_offset,
  output logic [rbsa_pkg::SIZE_W-1:0]              length,
  output logic                                     is_empty
);
  import rbsa_pkg::*;

  // Largest size as a 17-bit value; only used when it is below the register range.
  localparam logic [SIZE_W-1:0] MAX_SIZE = SIZE_W'(MAX_BUFFER_BYTES);
  localparam logic [SIZE_W-1:0] RESET_SIZE =
    (RESET_BUFFER_BYTES > MAX_BUFFER_BYTES) ? MAX_SIZE : SIZE_W'(RESET_BUFFER_BYTES);

  logic [SIZE_W-1:0] buf_size;
  logic [MASK_W-1:0] align_mask;
  logic [SIZE_W-1:0] read_offset;
  logic [SIZE_W-1:0] write_offset;

  logic [SIZE_W-1:0] size_eff;
  logic [SIZE_W:0]   sz;
  logic [SIZE_W:0]   mask_ext;
  logic [SIZE_W-1:0] alloc_start;
  logic [SIZE_W:0]   alloc_end_raw;
  logic [SIZE_W-1:0] alloc_end;
  logic              alloc_hit;
  logic [SIZE_W-1:0] read_base;
  logic [SIZE_W-1:0] read_end;
  logic [SIZE_W-1:0] room;
  logic [SIZE_W-1:0] read_offset_next;
  logic [SIZE_W-1:0] write_offset_next;
  status_t           status_next;
  logic [SIZE_W-1:0] start_next;
  logic [SIZE_W-1:0] length_next;

  // Rounding mask from the highest set bit of the alignment; zero acts as one.
  function automatic logic [MASK_W-1:0] align_to_mask(input logic [ALIGN_W-1:0] a);
    logic [ALIGN_W-1:0] s;
    s = a | (a >> 1);
    s = s | (s >> 2);
    s = s | (s >> 4);
    s = s | (s >> 8);
    return s[ALIGN_W-1:1];
  endfunction

  // The buffer size is saturated to its legal range when written.
  always_comb begin
    if (cfg_data < SIZE_W'(2)) begin
      size_eff = SIZE_W'(2);
    end else if ({15'd0, cfg_data} > 32'(MAX_BUFFER_BYTES)) begin
      size_eff = MAX_SIZE;
    end else begin
      size_eff = cfg_data;
    end
  end

  // Request size rounded up to the alignment.
  assign mask_ext = {{(SIZE_W+1-MASK_W){1'b0}}, align_mask};
  assign sz       = ({1'b0, req_size} + mask_ext) & ~mask_ext;

  // Allocation region: starts at the write offset, wrapped at the end, clipped at the end.
  assign alloc_start   = (write_offset != buf_size) ? write_offset : '0;
  assign alloc_end_raw = {1'b0, alloc_start} + sz;
  assign alloc_end     = (alloc_end_raw > {1'b0, buf_size}) ? buf_size
                                                            : alloc_end_raw[SIZE_W-1:0];
  assign alloc_hit     = (read_offset != write_offset) && (alloc_start <= read_offset) &&
                         (read_offset <= alloc_end);

  // Room left for a finish-read before the read offset saturates.
  assign room = buf_size - read_offset;

  // Next offsets and result for the presented request.
  always_comb begin
    read_offset_next  = read_offset;
    write_offset_next = write_offset;
    status_next       = ST_OK;
    start_next        = '0;
    length_next       = '0;
    read_base         = read_offset;
    read_end          = write_offset;
    case (func_t'(func))
      FN_ALLOC: begin
        if (sz >= {1'b0, buf_size}) begin
          status_next = ST_TOO_LARGE;
        end else if (alloc_hit) begin
          status_next = ST_BLOCKED;
        end else begin
          write_offset_next = alloc_end;
          start_next        = alloc_start;
          length_next       = alloc_end - alloc_start;
        end
      end
      FN_BEGIN: begin
        if (write_offset >= read_offset) begin
          read_end = write_offset;
        end else if (read_offset == buf_size) begin
          read_base = '0;
          read_end  = write_offset;
        end else begin
          read_end = buf_size;
        end
        read_offset_next = read_base;
        if (read_base < read_end) begin
          start_next  = read_base;
          length_next = read_end - read_base;
        end else begin
          status_next = ST_NO_DATA;
        end
      end
      FN_FINISH: begin
        if (sz >= {1'b0, room}) begin
          read_offset_next = buf_size;
        end else begin
          read_offset_next = read_offset + sz[SIZE_W-1:0];
        end
      end
      FN_QUERY: begin
        status_next = ST_OK;
      end
      default: status_next = ST_OK;
    endcase
  end

  // Configuration and offset registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_size     <= RESET_SIZE;
      align_mask   <= '0;
      read_offset  <= '0;
      write_offset <= '0;
    end else if (cfg_write) begin
      if (cfg_index == REG_BUFFER_SIZE) begin
        buf_size     <= size_eff;
        read_offset  <= '0;
        write_offset <= '0;
      end else if (cfg_index == REG_ALIGNMENT) begin
        align_mask <= align_to_mask(cfg_data[ALIGN_W-1:0]);
      end
    end else if (cmd.step) begin
      read_offset  <= read_offset_next;
      write_offset <= write_offset_next;
    end
  end

  // Result register, loaded once per accepted item.
  always_ff @(posedge clk) begin
    if (cmd.step) begin
      status       <= status_next;
      start_offset <= start_next[START_W-1:0];
      length       <= length_next;
      is_empty     <= (read_offset_next == write_offset_next);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/ring_buffer_space_allocator_unit.sv
// Ring buffer space allocator: tracks read and write offsets of a byte ring buffer.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request item: func selects
//   allocate, begin read, finish read or query empty; req_size gives the bytes.
//   Output channel (out_valid / out_stall) returns one result item per request:
//   status, start_offset, length and is_empty.
//   Each item is worked out in the cycle it is accepted and its result is shown
//   from the next cycle, and an item can be taken every cycle while the output
//   is not stalled; the offset update is a single compare-and-add step.
//   The result register frees up in the same cycle it is taken, so a stalled
//   receiver holds the result and stalls the input only while the register is full.
//   Configuration writes (cfg_write, cfg_index, cfg_data) take effect at once; the
//   user must make them only while no item is in flight, as the block does not
//   enforce this. Writing the buffer size returns both offsets to zero.
//   Reset (rst, synchronous) empties the result register, clears both offsets and
//   sets a 4096-byte buffer with byte alignment.
`default_nettype none

module ring_buffer_space_allocator_unit #(
  parameter int unsigned MAX_BUFFER_BYTES = rbsa_pkg::MAX_BUFFER_BYTES_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_write,
  input  wire logic [rbsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [rbsa_pkg::SIZE_W-1:0]         cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [1:0]                          func,
  input  wire logic [rbsa_pkg::SIZE_W-1:0]         req_size,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [1:0]                               status,
  output logic [rbsa_pkg::START_W-1:0]             start_offset,
  output logic [rbsa_pkg::SIZE_W-1:0]              length,
  output logic                                     is_empty
);
  import rbsa_pkg::*;

  ctrl_cmd_t cmd;

  // Handshake and result register control.
  rbsa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // Offsets, configuration and result computation.
  rbsa_dp #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .func         (func),
    .req_size     (req_size),
    .status       (status),
    .start_offset (start_offset),
    .length       (length),
    .is_empty     (is_empty)
  );

`ifndef NO_ASSERTIONS
  // An accepted item always has its result ready in the following cycle.
  a_accept_gives_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> out_valid)
    else $error("accepted item produced no result");

  // Refused requests carry no region.
  a_refused_no_region: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |-> (start_offset == '0 && length == '0))
    else $error("refused request reported a region");

  // A readable span is never reported from an empty buffer.
  a_span_not_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_OK && length != '0 && $past(func) == FN_BEGIN)
      |-> !is_empty)
    else $error("readable span reported while empty");

  // The result register is empty straight after reset.
  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result pending after reset");
`endif

endmodule

`default_nettype wire
